// File: src/ptd_pkg.sv
// Shared types and constants of the periodic task dispatcher.
package ptd_pkg;

    localparam int unsigned MAX_TASKS_DEF = 8;
    localparam int unsigned RESULT_CAP    = 8;
    localparam int unsigned US_PER_S      = 1000000;
    localparam logic [31:0] CLK_HZ_RESET  = 32'd168000000;
    localparam int unsigned PROD_W        = 52;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] KIND_FIRE  = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_STATS = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] interval_ms;
        logic [2:0]  task_index;
        logic [31:0] exec_cycles;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic        accepted;
        logic [31:0] run_count;
        logic [31:0] worst_time_us;
        logic        last;
    } t_res_word;

    typedef struct packed {
        logic        start;
        logic [31:0] cycles;
        logic [31:0] clock_hz;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] time_us;
    } t_div_rsp;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] last_run;
        logic [31:0] runs;
        logic [31:0] worst;
    } t_entry;

endpackage

// File: src/ptd_time_div.sv
// Cycles-to-microseconds converter: registered multiply, then bit-serial restoring divide.
module ptd_time_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptd_pkg::t_div_req i_req,
    output ptd_pkg::t_div_rsp o_rsp
);
    import ptd_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic [PROD_W-1:0] r_prod, n_prod;
    logic [31:0]       r_rem, n_rem;
    logic [31:0]       r_div, n_div;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_run, n_run;
    logic              r_done, n_done;
    logic [32:0]       w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_prod[PROD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_prod = r_prod;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_req.start) begin
            n_prod = PROD_W'(i_req.cycles) * PROD_W'(US_PER_S);
            n_div  = i_req.clock_hz;
            n_rem  = '0;
            n_cnt  = '0;
            n_run  = 1'b1;
        end else if (r_run) begin
            // shift dividend out at the top, quotient bit in at the bottom
            n_rem  = w_fit ? 32'(w_trial - {1'b0, r_div}) : w_trial[31:0];
            n_prod = {r_prod[PROD_W-2:0], w_fit};
            n_cnt  = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(PROD_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_cnt  <= n_cnt;
    end

    // saturate quotients that do not fit in 32 bits
    assign o_rsp.done    = r_done;
    assign o_rsp.time_us = (|r_prod[PROD_W-1:32]) ? 32'hFFFF_FFFF : r_prod[31:0];

endmodule

// File: src/periodic_task_dispatcher.sv
// Periodic task dispatcher: task table memory, sequencer and result register.
// Add answers from idle; read passes a table read and an evaluate state; report also waits
// for the divider (52-step divide after a multiply). Tick: read and evaluate states per entry
// scanned, then a closing state (none for an empty table); a fire is output once the next due
// entry is found, the final one from the closing state. Commands: one at a time.
// Reset: synchronous, clears time and table fill, presets clock register; receiver cannot stall.
module periodic_task_dispatcher #(
    parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ptd_pkg::t_cmd_word i_cmd,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    output logic               o_res_stb,
    output ptd_pkg::t_res_word o_res
);
    import ptd_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TK_RD  = 3'd1;
    localparam logic [2:0] S_TK_EV  = 3'd2;
    localparam logic [2:0] S_TK_END = 3'd3;
    localparam logic [2:0] S_ST_RD  = 3'd4;
    localparam logic [2:0] S_ST_EV  = 3'd5;

    t_entry mem [MAX_TASKS];

    logic [2:0]    r_state, n_state;
    logic [31:0]   r_clk_hz;
    logic [31:0]   r_now, n_now;
    logic [CW-1:0] r_used, n_used;
    logic [IW-1:0] r_idx, n_idx;
    logic [3:0]    r_cnt, n_cnt;
    t_cmd_word     r_cmd, n_cmd;
    t_res_word     r_pend, n_pend;
    logic          r_pend_v, n_pend_v;
    t_res_word     r_out, n_out;
    logic          r_out_stb, n_out_stb;
    t_entry        r_rd_data;

    logic          w_rd_en;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;

    logic          w_accept;
    logic          w_due;
    logic [CW-1:0] w_idx_nx;
    logic          w_bad_idx;
    logic [31:0]   w_worst;
    t_div_req      w_div_req;
    t_div_rsp      w_div_rsp;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_rd_en  = (r_state == S_TK_RD) || (r_state == S_ST_RD);
    assign w_due    = (32'(r_now - r_rd_data.last_run) >= r_rd_data.period);
    assign w_idx_nx = CW'(r_idx) + CW'(1);
    assign w_bad_idx = (8'(i_cmd.task_index) >= 8'(r_used));
    assign w_worst  = (w_div_rsp.time_us > r_rd_data.worst) ? w_div_rsp.time_us
                                                            : r_rd_data.worst;

    assign w_div_req.start    = w_accept && (i_cmd.command == CMD_REPORT) && !w_bad_idx;
    assign w_div_req.cycles   = i_cmd.exec_cycles;
    assign w_div_req.clock_hz = (r_clk_hz == 32'd0) ? 32'd1 : r_clk_hz;

    ptd_time_div u_time_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_now     = r_now;
        n_used    = r_used;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_cmd     = r_cmd;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_out     = r_out;
        n_out_stb = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.command) inside
                        CMD_TICK: begin
                            n_now    = r_now + 32'd1;
                            n_idx    = '0;
                            n_cnt    = '0;
                            n_pend_v = 1'b0;
                            if (r_used != '0) begin
                                n_state = S_TK_RD;
                            end
                        end
                        CMD_ADD: begin
                            n_out_stb = 1'b1;
                            n_out     = '{kind: KIND_ADD, slot: 3'd0, accepted: 1'b0,
                                          run_count: 32'd0, worst_time_us: 32'd0,
                                          last: 1'b1};
                            if (r_used < CW'(MAX_TASKS)) begin
                                w_we             = 1'b1;
                                w_waddr          = IW'(r_used);
                                w_wdata.period   = i_cmd.interval_ms;
                                w_wdata.last_run = r_now;
                                w_wdata.runs     = '0;
                                w_wdata.worst    = '0;
                                n_used           = r_used + CW'(1);
                                n_out.slot       = 3'(r_used);
                                n_out.accepted   = 1'b1;
                            end
                        end
                        CMD_REPORT, CMD_READ: begin
                            if (w_bad_idx) begin
                                n_out_stb = 1'b1;
                                n_out     = '{kind: KIND_STATS, slot: i_cmd.task_index,
                                              accepted: 1'b0, run_count: 32'd0,
                                              worst_time_us: 32'd0, last: 1'b1};
                            end else begin
                                n_idx   = IW'(i_cmd.task_index);
                                n_state = S_ST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TK_RD: begin
                n_state = S_TK_EV;
            end
            S_TK_EV: begin
                if (w_due) begin
                    w_we             = 1'b1;
                    w_wdata.last_run = r_now;
                    w_wdata.runs     = r_rd_data.runs + 32'd1;
                    // hold this fire until we know whether it is the final one
                    if (r_pend_v) begin
                        n_out_stb = 1'b1;
                        n_out     = r_pend;
                    end
                    n_pend   = '{kind: KIND_FIRE, slot: 3'(r_idx), accepted: 1'b1,
                                 run_count: r_rd_data.runs + 32'd1,
                                 worst_time_us: r_rd_data.worst, last: 1'b0};
                    n_pend_v = 1'b1;
                    n_cnt    = r_cnt + 4'd1;
                end
                if ((w_idx_nx >= r_used) || (w_due && (r_cnt == 4'(RESULT_CAP - 1)))) begin
                    n_state = S_TK_END;
                end else begin
                    n_idx   = IW'(w_idx_nx);
                    n_state = S_TK_RD;
                end
            end
            S_TK_END: begin
                if (r_pend_v) begin
                    n_out_stb = 1'b1;
                    n_out     = r_pend;
                    n_out.last = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end
            S_ST_RD: begin
                n_state = S_ST_EV;
            end
            S_ST_EV: begin
                if (r_cmd.command != CMD_REPORT || w_div_rsp.done) begin
                    n_out_stb = 1'b1;
                    n_out     = '{kind: KIND_STATS, slot: r_cmd.task_index, accepted: 1'b1,
                                  run_count: r_rd_data.runs,
                                  worst_time_us: r_rd_data.worst, last: 1'b1};
                    if (r_cmd.command == CMD_REPORT) begin
                        w_we                = 1'b1;
                        w_wdata.worst       = w_worst;
                        n_out.worst_time_us = w_worst;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= '0;
            r_used    <= '0;
            r_pend_v  <= 1'b0;
            r_out_stb <= 1'b0;
            r_clk_hz  <= CLK_HZ_RESET;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_used    <= n_used;
            r_pend_v  <= n_pend_v;
            r_out_stb <= n_out_stb;
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_data;
            end
        end
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_cmd  <= n_cmd;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_res_stb = r_out_stb;
    assign o_res     = r_out;

endmodule
